### src/matrix3_inverse_macros.svh
// Assertion macros shared by the matrix3_inverse checker.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// Same-cycle implication, masked during reset
`define MI3_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold on the cycle after reset is sampled low
`define MI3_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

### src/mi3_pkg.sv
// Shared types and constants for the 3x3 fixed-point matrix inverse.
package mi3_pkg;

    localparam int C_WORD_BITS   = 32;
    localparam int C_FRAC_BITS   = 16;
    localparam int C_ENTRIES     = 9;
    // adjugate entry: difference of two 2W-bit products
    localparam int C_ADJ_BITS    = 2 * C_WORD_BITS + 1;
    // determinant: sum of three W x (2W+1) products, with headroom
    localparam int C_DET_BITS    = 3 * C_WORD_BITS + 3;
    localparam int C_QUEUE_DEPTH = 4;

    typedef logic signed [C_WORD_BITS-1:0] t_fix;

    typedef struct packed {
        t_fix m00;
        t_fix m01;
        t_fix m02;
        t_fix m10;
        t_fix m11;
        t_fix m12;
        t_fix m20;
        t_fix m21;
        t_fix m22;
    } t_in_word;

    typedef struct packed {
        t_fix r00;
        t_fix r01;
        t_fix r02;
        t_fix r10;
        t_fix r11;
        t_fix r12;
        t_fix r20;
        t_fix r21;
        t_fix r22;
        logic singular;
        logic clamped;
    } t_out_word;

    // classified job handed from front to back
    typedef struct packed {
        logic [C_ENTRIES-1:0][C_ADJ_BITS-1:0] adj_mag;
        logic [C_ENTRIES-1:0]                 neg;
        logic [C_DET_BITS-1:0]                det_mag;
        logic                                 singular;
    } t_job;

endpackage

### src/mi3_front.sv
// Front end: cofactor products, adjugate, determinant and sign classification.
module mi3_front import mi3_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    output logic     o_job_valid,
    input  logic     i_job_ready,
    output t_job     o_job
);

    localparam int W  = C_WORD_BITS;
    localparam int PW = 2 * W;
    localparam int AW = C_ADJ_BITS;
    localparam int DW = C_DET_BITS;
    localparam int NE = C_ENTRIES;
    localparam int NP = 2 * C_ENTRIES;

    function automatic logic signed [PW-1:0] f_mul(input t_fix a, input t_fix b);
        return PW'(a) * PW'(b);
    endfunction

    logic [4:0] r_vld;
    logic       w_ce;

    logic signed [PW-1:0] r_prod [NP];
    t_fix                 r_m0_s1 [3];
    logic signed [AW-1:0] r_adj_s2 [NE];
    t_fix                 r_m0_s2 [3];
    logic signed [PW:0]   r_plo [3];
    logic signed [PW:0]   r_phi [3];
    logic signed [AW-1:0] r_adj_s3 [NE];
    logic signed [DW-1:0] r_det;
    logic signed [AW-1:0] r_adj_s4 [NE];
    t_job                 r_job;
    logic signed [DW-1:0] w_det;

    // whole front advances together
    assign w_ce        = !r_vld[4] || i_job_ready;
    assign o_in_ready  = w_ce;
    assign o_job_valid = r_vld[4];
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[3:0], i_in_valid};
        end
    end

    // stage 1: the eighteen 2x2 products, adjugate entry k = p[2k] - p[2k+1]
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_prod[0]  <= f_mul(i_in_word.m11, i_in_word.m22);
            r_prod[1]  <= f_mul(i_in_word.m12, i_in_word.m21);
            r_prod[2]  <= f_mul(i_in_word.m02, i_in_word.m21);
            r_prod[3]  <= f_mul(i_in_word.m01, i_in_word.m22);
            r_prod[4]  <= f_mul(i_in_word.m01, i_in_word.m12);
            r_prod[5]  <= f_mul(i_in_word.m02, i_in_word.m11);
            r_prod[6]  <= f_mul(i_in_word.m12, i_in_word.m20);
            r_prod[7]  <= f_mul(i_in_word.m10, i_in_word.m22);
            r_prod[8]  <= f_mul(i_in_word.m00, i_in_word.m22);
            r_prod[9]  <= f_mul(i_in_word.m02, i_in_word.m20);
            r_prod[10] <= f_mul(i_in_word.m02, i_in_word.m10);
            r_prod[11] <= f_mul(i_in_word.m00, i_in_word.m12);
            r_prod[12] <= f_mul(i_in_word.m10, i_in_word.m21);
            r_prod[13] <= f_mul(i_in_word.m11, i_in_word.m20);
            r_prod[14] <= f_mul(i_in_word.m01, i_in_word.m20);
            r_prod[15] <= f_mul(i_in_word.m00, i_in_word.m21);
            r_prod[16] <= f_mul(i_in_word.m00, i_in_word.m11);
            r_prod[17] <= f_mul(i_in_word.m01, i_in_word.m10);
            r_m0_s1[0] <= i_in_word.m00;
            r_m0_s1[1] <= i_in_word.m01;
            r_m0_s1[2] <= i_in_word.m02;
        end
    end

    // stage 2: adjugate
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < NE; k++) begin
                r_adj_s2[k] <= AW'(r_prod[2*k]) - AW'(r_prod[2*k+1]);
            end
            r_m0_s2 <= r_m0_s1;
        end
    end

    // stage 3: det by row 0 times adjugate column 0, products split in halves
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int j = 0; j < 3; j++) begin
                r_plo[j] <= (PW+1)'($signed({1'b0, r_adj_s2[3*j][W-1:0]}))
                          * (PW+1)'(r_m0_s2[j]);
                r_phi[j] <= (PW+1)'($signed(r_adj_s2[3*j][AW-1:W]))
                          * (PW+1)'(r_m0_s2[j]);
            end
            r_adj_s3 <= r_adj_s2;
        end
    end

    // stage 4: sum of partial products
    always_comb begin
        w_det = '0;
        for (int j = 0; j < 3; j++) begin
            w_det = w_det + (DW'(r_phi[j]) <<< W) + DW'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_det    <= w_det;
            r_adj_s4 <= r_adj_s3;
        end
    end

    // stage 5: magnitudes, quotient signs, singular flag
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < NE; k++) begin
                r_job.adj_mag[k] <= r_adj_s4[k][AW-1] ? AW'(-r_adj_s4[k]) : AW'(r_adj_s4[k]);
                r_job.neg[k]     <= r_adj_s4[k][AW-1] ^ r_det[DW-1];
            end
            r_job.det_mag  <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_job.singular <= (r_det == '0);
        end
    end

endmodule

### src/mi3_queue.sv
// Short job queue between the front end and the divider back end.
module mi3_queue import mi3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    localparam int DEPTH = C_QUEUE_DEPTH;
    localparam int PB    = $clog2(DEPTH);

    logic [PB-1:0] r_wr;
    logic [PB-1:0] r_rd;
    logic [PB:0]   r_cnt;
    t_job          r_mem [DEPTH];
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != (PB+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PB'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PB'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### src/mi3_back.sv
// Back end: nine pipelined restoring dividers, saturation and output register.
module mi3_back import mi3_pkg::*; #(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int W  = C_WORD_BITS;
    localparam int DW = C_DET_BITS;
    localparam int XW = DW + W;
    localparam int NE = C_ENTRIES;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    logic [W:0]    r_vld;
    logic          r_ov;
    logic          w_ce;
    logic [XW-1:0] r_rem [W][NE];
    logic [DW-1:0] r_d   [W];
    logic [W-1:0]  r_q   [W+1][NE];
    logic [NE-1:0] r_big [W+1];
    logic [NE-1:0] r_neg [W+1];
    logic          r_sing [W+1];
    logic [XW-1:0] w_num [NE];
    logic [NE-1:0] w_big;
    t_fix          w_res [NE];
    logic          w_sat;
    t_out_word     r_out;

    assign w_ce        = !r_ov || i_out_ready;
    assign o_job_ready = w_ce;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (w_ce) begin
            r_vld <= {r_vld[W-1:0], i_job_valid};
            r_ov  <= r_vld[W];
        end
    end

    // entry stage: scaled numerator and quotient overflow test
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            w_num[k] = XW'(i_job.adj_mag[k]) << (2 * FRAC_BITS);
            w_big[k] = (w_num[k] >= (XW'(i_job.det_mag) << W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < NE; k++) begin
                r_rem[0][k] <= w_num[k];
                r_q[0][k]   <= '0;
            end
            r_big[0]  <= w_big;
            r_neg[0]  <= i_job.neg;
            r_d[0]    <= i_job.det_mag;
            r_sing[0] <= i_job.singular;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar s = 0; s < W; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_big[s+1]  <= r_big[s];
                r_neg[s+1]  <= r_neg[s];
                r_sing[s+1] <= r_sing[s];
            end
        end
        if (s < W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_d[s+1] <= r_d[s];
                end
            end
        end
        for (genvar k = 0; k < NE; k++) begin : g_ent
            logic [XW-1:0] w_trial;
            logic          w_ge;
            assign w_trial = XW'(r_d[s]) << (W - 1 - s);
            assign w_ge    = (r_rem[s][k] >= w_trial);
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_q[s+1][k] <= r_q[s][k] | (W'(w_ge) << (W - 1 - s));
                end
            end
            if (s < W - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (w_ce) begin
                        r_rem[s+1][k] <= w_ge ? r_rem[s][k] - w_trial : r_rem[s][k];
                    end
                end
            end
        end
    end

    // sign, saturation and singular override
    always_comb begin
        w_sat = 1'b0;
        for (int k = 0; k < NE; k++) begin
            if (r_sing[W]) begin
                w_res[k] = '0;
            end else if (r_neg[W][k]) begin
                if (r_big[W][k] || (r_q[W][k] > HALF)) begin
                    w_res[k] = HALF;
                    w_sat    = 1'b1;
                end else begin
                    w_res[k] = -r_q[W][k];
                end
            end else begin
                if (r_big[W][k] || (r_q[W][k] > HALF - 1'b1)) begin
                    w_res[k] = HALF - 1'b1;
                    w_sat    = 1'b1;
                end else begin
                    w_res[k] = r_q[W][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out.r00      <= w_res[0];
            r_out.r01      <= w_res[1];
            r_out.r02      <= w_res[2];
            r_out.r10      <= w_res[3];
            r_out.r11      <= w_res[4];
            r_out.r12      <= w_res[5];
            r_out.r20      <= w_res[6];
            r_out.r21      <= w_res[7];
            r_out.r22      <= w_res[8];
            r_out.singular <= r_sing[W];
            r_out.clamped  <= w_sat;
        end
    end

endmodule

### src/matrix3_inverse.sv
// Path from an accepted word to its result: 5 front stages, queue write, divider entry
// stage, 32 divider stages, output register. Throughput: one matrix per cycle unless
// back-pressure stalls; each of the 9 divider pipelines retires one bit a stage.
// Reset: synchronous active low; empties the pipelines and the queue, no clearing pass.
// Top level: 3x3 fixed-point matrix inverse by adjugate and determinant.
module matrix3_inverse import mi3_pkg::*; #(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic f_valid;
    logic f_ready;
    t_job f_job;
    logic q_valid;
    logic q_ready;
    t_job q_job;

    // classify
    mi3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    // decouple
    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    // divide
    mi3_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

### src/mi3_checker.sv
// Port-level checker for matrix3_inverse and its bind.
`include "matrix3_inverse_macros.svh"

module mi3_checker import mi3_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    logic w_all_zero;

    // singular results carry an all-zero matrix
    assign w_all_zero = (o_out_word.r00 == '0) && (o_out_word.r01 == '0)
                     && (o_out_word.r02 == '0) && (o_out_word.r10 == '0)
                     && (o_out_word.r11 == '0) && (o_out_word.r12 == '0)
                     && (o_out_word.r20 == '0) && (o_out_word.r21 == '0)
                     && (o_out_word.r22 == '0);

    `MI3_ASSERT_NEXT(a_hold_valid, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
    `MI3_ASSERT_NEXT(a_hold_word, o_out_valid && !i_out_ready, $stable(o_out_word), "word moved")
    `MI3_ASSERT_SAME(a_singular, o_out_valid && o_out_word.singular, !o_out_word.clamped && w_all_zero, "bad singular word")
    `MI3_ASSERT_RESET(a_reset, !o_out_valid, "valid after reset")

endmodule

bind matrix3_inverse mi3_checker u_chk (.*);

### tb/tb_matrix3_inverse.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
module tb_matrix3_inverse;
    import mi3_pkg::*;

    localparam int W      = C_WORD_BITS;
    localparam int F      = C_FRAC_BITS;
    localparam int N_RAND = 1950;
    localparam int LIMIT  = 1000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    matrix3_inverse dut (.*);

    always #10 i_clk = ~i_clk;

    // exact inverse of one matrix, truncated toward zero, saturated
    function automatic t_out_word inverse_of(t_in_word m);
        logic signed [255:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
        logic signed [255:0] x00, x01, x02, x10, x11, x12, x20, x21, x22;
        logic signed [255:0] det, adj[9], q;
        logic signed [255:0] hi, lo;
        t_fix res[9];
        t_out_word r;
        logic sat;
        x00 = m.m00; x01 = m.m01; x02 = m.m02;
        x10 = m.m10; x11 = m.m11; x12 = m.m12;
        x20 = m.m20; x21 = m.m21; x22 = m.m22;
        det = x00*x11*x22 + x01*x12*x20 + x02*x10*x21
            - x01*x10*x22 - x00*x12*x21 - x02*x11*x20;
        adj[0] = x11*x22 - x12*x21;
        adj[1] = x02*x21 - x01*x22;
        adj[2] = x01*x12 - x02*x11;
        adj[3] = x12*x20 - x10*x22;
        adj[4] = x00*x22 - x02*x20;
        adj[5] = x02*x10 - x00*x12;
        adj[6] = x10*x21 - x11*x20;
        adj[7] = x01*x20 - x00*x21;
        adj[8] = x00*x11 - x01*x10;
        hi  = (256'sd1 <<< (W-1)) - 1;
        lo  = -(256'sd1 <<< (W-1));
        sat = 1'b0;
        r   = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        for (int i = 0; i < 9; i++) begin
            // SV signed division truncates toward zero
            q = (adj[i] <<< (2*F)) / det;
            if (q > hi) begin
                q = hi; sat = 1'b1;
            end else if (q < lo) begin
                q = lo; sat = 1'b1;
            end
            res[i] = q[W-1:0];
        end
        r.r00 = res[0]; r.r01 = res[1]; r.r02 = res[2];
        r.r10 = res[3]; r.r11 = res[4]; r.r12 = res[5];
        r.r20 = res[6]; r.r21 = res[7]; r.r22 = res[8];
        r.clamped = sat;
        return r;
    endfunction

    class inverse_scoreboard;
        t_out_word pending[$];
        int        mismatches = 0;

        function void note_matrix(t_in_word m);
            pending.push_back(inverse_of(m));
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h actual %h", exp_w, got);
            end
        endfunction
    endclass

    inverse_scoreboard sb = new();

    // receiver: random stall, check accepted words
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_word);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_fix rand_entry();
        case ($urandom_range(5))
            0: return t_fix'($urandom);
            1: return t_fix'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
            2: return t_fix'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
            3: return t_fix'(32'h8000_0000 ^ ($urandom_range(3)));
            4: return t_fix'(($urandom_range(8) - 4) << F);
            default: return t_fix'($urandom_range(3) - 1);
        endcase
    endfunction

    // idle cycles drop valid; back to back words keep it high
    task automatic send_matrix(t_in_word m);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= m;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_matrix(m);
    endtask

    task automatic send_random(int n);
        t_in_word m;
        for (int k = 0; k < n; k++) begin
            m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                 rand_entry(), rand_entry(), rand_entry(), rand_entry()};
            // occasionally force a singular matrix: duplicate a row
            if ($urandom_range(9) == 0) begin
                m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
            end
            send_matrix(m);
        end
    endtask

    function automatic t_in_word diag(t_fix a, t_fix b, t_fix c);
        t_in_word m;
        m = '0;
        m.m00 = a; m.m11 = b; m.m22 = c;
        return m;
    endfunction

    initial begin
        t_in_word m;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, scaled, zero, singular, extremes, tiny and huge
        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        send_matrix(diag(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
        send_matrix('0);
        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 0));
        send_matrix(diag(1, 1, 1));
        send_matrix(diag(-1, 1, -1));
        send_matrix(diag(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_matrix(diag(32'sh8000_0000, 32'sh7fff_ffff, 1));
        send_matrix({9{32'hffff_ffff}});
        send_matrix({9{32'h7fff_ffff}});
        send_matrix({32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                     32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                     32'sh0001_0000, 32'sh0000_0001, 32'sh8000_0000});
        m = diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        m.m01 = 32'sh0003_0000; m.m12 = -32'sh0002_0000; m.m20 = 32'sh0000_4000;
        send_matrix(m);
        send_matrix({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                     32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000,
                     32'sh0007_0000, 32'sh0008_0000, 32'sh000a_0000});

        // idle phases: none, sender idle, receiver stall, both
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(N_RAND / 4);
        send_idle_pct = 79; recv_stall_pct = 0;  send_random(N_RAND / 4);
        send_idle_pct = 0;  recv_stall_pct = 79; send_random(N_RAND / 4);
        send_idle_pct = 29; recv_stall_pct = 29; send_random(N_RAND / 4);
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### matrix3_inverse.f
+incdir+src
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_queue.sv
src/mi3_back.sv
src/matrix3_inverse.sv
src/mi3_checker.sv
tb/tb_matrix3_inverse.sv
